>>> rtl/core/cose_pkg.sv
package cose_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned OPC_W    = 7;
	localparam int unsigned PCNT_W   = 5;
	localparam int unsigned REASON_W = 3;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned ROM_DEPTH = 128;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_OPCODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CUE_OPCODE  = 1'd1;

	localparam logic [OPC_W-1:0] TIME_OPCODE_RST = 7'd1;
	localparam logic [OPC_W-1:0] CUE_OPCODE_RST  = 7'd24;

	// stop reasons
	localparam logic [REASON_W-1:0] STOP_NONE    = 3'd0;
	localparam logic [REASON_W-1:0] STOP_END     = 3'd1;
	localparam logic [REASON_W-1:0] STOP_UNKNOWN = 3'd2;
	localparam logic [REASON_W-1:0] STOP_TRUNC   = 3'd3;
	localparam logic [REASON_W-1:0] STOP_OUT     = 3'd4;

	typedef enum logic [3:0] {
		PH_SIG  = 4'b0001,
		PH_OPC  = 4'b0010,
		PH_PAR  = 4'b0100,
		PH_STOP = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_OTHER = 2'd0,
		KIND_TIME  = 2'd1,
		KIND_CUE   = 2'd2
	} op_kind_t;

	typedef struct packed {
		logic [OPC_W-1:0] time_opcode;
		logic [OPC_W-1:0] cue_opcode;
	} cfg_t;

	typedef struct packed {
		logic                    emit;
		logic                    cue;
		logic signed [WORD_W-1:0] cue_time;
		logic signed [WORD_W-1:0] line_index;
		logic [REASON_W-1:0]     reason;
	} result_t;

	// parameter word count per opcode; opcodes from 107 up take none
	localparam logic [PCNT_W-1:0] PARAM_ROM [ROM_DEPTH] = '{
		5'd0, 5'd1, 5'd4, 5'd2, 5'd2, 5'd2, 5'd7, 5'd4, 5'd2, 5'd6,
		5'd2, 5'd1, 5'd6, 5'd2, 5'd1, 5'd1, 5'd3, 5'd2, 5'd3, 5'd5,
		5'd5, 5'd4, 5'd4, 5'd5, 5'd2, 5'd0, 5'd2, 5'd4, 5'd2, 5'd2,
		5'd1, 5'd21, 5'd0, 5'd3, 5'd2, 5'd5, 5'd1, 5'd1, 5'd7, 5'd1,
		5'd1, 5'd2, 5'd1, 5'd2, 5'd1, 5'd2, 5'd3, 5'd3, 5'd1, 5'd2,
		5'd2, 5'd3, 5'd6, 5'd6, 5'd1, 5'd1, 5'd2, 5'd3, 5'd1, 5'd2,
		5'd2, 5'd4, 5'd4, 5'd1, 5'd2, 5'd1, 5'd2, 5'd1, 5'd1, 5'd3,
		5'd3, 5'd3, 5'd2, 5'd1, 5'd9, 5'd3, 5'd2, 5'd4, 5'd2, 5'd3,
		5'd2, 5'd24, 5'd1, 5'd2, 5'd1, 5'd3, 5'd1, 5'd3, 5'd4, 5'd1,
		5'd2, 5'd6, 5'd3, 5'd2, 5'd3, 5'd3, 5'd4, 5'd1, 5'd1, 5'd3,
		5'd3, 5'd4, 5'd1, 5'd3, 5'd3, 5'd8, 5'd2,
		5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
		5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
		5'd0
	};

endpackage

>>> rtl/core/cose_cfg_regs.sv
module cose_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cose_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cose_pkg::OPC_W-1:0]     cfg_data,
	output cose_pkg::cfg_t                cfg
);
	import cose_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_opcode <= TIME_OPCODE_RST;
			cfg_q.cue_opcode  <= CUE_OPCODE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TIME_OPCODE: cfg_q.time_opcode <= cfg_data;
				CFG_CUE_OPCODE:  cfg_q.cue_opcode  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/core/cose_parser.sv
module cose_parser #(
	parameter int unsigned OP_COUNT = 107
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       fire,
	input  logic [cose_pkg::WORD_W-1:0] word,
	input  logic                       last_word,
	input  cose_pkg::cfg_t             cfg,
	output cose_pkg::result_t          res
);
	import cose_pkg::*;

	phase_t             phase_q, phase_n;
	logic [PCNT_W-1:0]  params_left_q, params_left_n;
	op_kind_t           op_kind_q, op_kind_n;
	logic               at_first_q, at_first_n;
	logic [WORD_W-1:0]  time_q, time_n;
	logic [WORD_W-1:0]  pending_q, pending_n;

	logic [PCNT_W-1:0]  pcount;
	logic [PCNT_W-1:0]  dec;
	logic               emit;
	logic               cue;
	logic [REASON_W-1:0] reason;

	assign pcount = PARAM_ROM[word[OPC_W-1:0]];
	assign dec    = params_left_q - PCNT_W'(1);

	always_comb begin
		phase_n       = phase_q;
		params_left_n = params_left_q;
		op_kind_n     = op_kind_q;
		at_first_n    = at_first_q;
		time_n        = time_q;
		pending_n     = pending_q;
		emit          = 1'b0;
		cue           = 1'b0;
		reason        = STOP_NONE;
		case (phase_q)
			PH_SIG: begin
				phase_n = PH_OPC;
				if (last_word) begin
					emit   = 1'b1;
					reason = STOP_OUT;
				end
			end
			PH_OPC: begin
				if (word == '0) begin
					emit   = 1'b1;
					reason = STOP_END;
				end else if (word >= WORD_W'(OP_COUNT)) begin
					emit   = 1'b1;
					reason = STOP_UNKNOWN;
				end else begin
					params_left_n = pcount;
					at_first_n    = 1'b1;
					if (word[OPC_W-1:0] == cfg.time_opcode)
						op_kind_n = KIND_TIME;
					else if (word[OPC_W-1:0] == cfg.cue_opcode)
						op_kind_n = KIND_CUE;
					else
						op_kind_n = KIND_OTHER;
					if (pcount == '0) begin
						if (last_word) begin
							emit   = 1'b1;
							reason = STOP_OUT;
						end
					end else begin
						phase_n = PH_PAR;
						if (last_word) begin
							emit   = 1'b1;
							reason = STOP_TRUNC;
						end
					end
				end
			end
			PH_PAR: begin
				if (at_first_q) begin
					if (op_kind_q == KIND_TIME)
						time_n = word;
					else if (op_kind_q == KIND_CUE)
						pending_n = word;
				end
				at_first_n    = 1'b0;
				params_left_n = dec;
				if (dec == '0) begin
					phase_n = PH_OPC;
					cue     = (op_kind_q == KIND_CUE);
					if (cue || last_word) begin
						emit   = 1'b1;
						reason = last_word ? STOP_OUT : STOP_NONE;
					end
				end else if (last_word) begin
					emit   = 1'b1;
					reason = STOP_TRUNC;
				end
			end
			PH_STOP: ;
			default: ;
		endcase
		if (reason != STOP_NONE)
			phase_n = PH_STOP;
	end

	assign res.emit       = emit;
	assign res.cue        = cue;
	assign res.cue_time   = cue ? time_n : '0;
	assign res.line_index = cue ? pending_n : '0;
	assign res.reason     = reason;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_SIG;
			params_left_q <= '0;
			op_kind_q     <= KIND_OTHER;
			at_first_q    <= 1'b0;
			time_q        <= '0;
			pending_q     <= '0;
		end else if (fire) begin
			phase_q       <= phase_n;
			params_left_q <= params_left_n;
			op_kind_q     <= op_kind_n;
			at_first_q    <= at_first_n;
			time_q        <= time_n;
			pending_q     <= pending_n;
		end
	end

endmodule

>>> rtl/core/chart_op_stream_cue_extractor.sv
// Chart op stream cue extractor. Feed the chart file one 32-bit word per
// request, signature first, with last_word set on the final whole word. Ops are
// walked using a parameter-count ROM; a request comes out when a lyric cue
// completes (cue_valid, cue_time in 1/100000 s ticks, line_index) or when
// parsing stops (stop_reason: 1 END op, 2 unknown opcode, 3 op cut short,
// 4 data ran out). A cue on the last word carries reason 4 in the same request.
// After a stop, words are swallowed silently until reset. Throughput is one
// word per clock while in_stall is low; a word lands in the input register,
// then one ROM lookup and a parameter-counter step decide the result, which is
// loaded into the result register once that register can take a new value.
// The result register decouples the sides: in_stall only rises when a result
// is held and out_stall is high. Write time_opcode and cue_opcode (register
// 0 and 1) only while idle; the block itself does not enforce this.
module chart_op_stream_cue_extractor #(
	parameter int unsigned OP_COUNT = 107
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cose_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cose_pkg::OPC_W-1:0]           cfg_data,
	// word stream in
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [cose_pkg::WORD_W-1:0]          word,
	input  logic                                last_word,
	// results out
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                cue_valid,
	output logic signed [cose_pkg::WORD_W-1:0]   cue_time,
	output logic signed [cose_pkg::WORD_W-1:0]   line_index,
	output logic [cose_pkg::REASON_W-1:0]        stop_reason
);
	import cose_pkg::*;

	cfg_t    cfg;
	result_t res;

	// input register
	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic              last_s1;

	// result register
	logic                     out_valid_q;
	logic                     cue_valid_q;
	logic signed [WORD_W-1:0] cue_time_q;
	logic signed [WORD_W-1:0] line_index_q;
	logic [REASON_W-1:0]      reason_q;

	logic advance;  // result register can take a new value
	logic fire;     // word in the input register is processed this cycle
	logic take;

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign take     = in_valid && !in_stall;

	cose_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cose_parser #(
		.OP_COUNT (OP_COUNT)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.word      (word_s1),
		.last_word (last_s1),
		.cfg       (cfg),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			word_s1 <= word;
			last_s1 <= last_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.emit) begin
			cue_valid_q  <= res.cue;
			cue_time_q   <= res.cue_time;
			line_index_q <= res.line_index;
			reason_q     <= res.reason;
		end
	end

	assign out_valid   = out_valid_q;
	assign cue_valid   = cue_valid_q;
	assign cue_time    = cue_time_q;
	assign line_index  = line_index_q;
	assign stop_reason = reason_q;

endmodule
